FILE: src/translated_block_tag_cache_assert.svh
// Assertion macros shared by the tag cache RTL.
// Each expands to a labeled concurrent assertion clocked by clk, disabled in reset.
`ifndef TRANSLATED_BLOCK_TAG_CACHE_ASSERT_SVH
`define TRANSLATED_BLOCK_TAG_CACHE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbc: next-cycle check failed");

`endif

FILE: src/tbc_pkg.sv
// Package for the translated block tag cache: field widths, command codes,
// controller states and the result/update structs. No dependencies.
`default_nettype none

package tbc_pkg;

    localparam int PC_W     = 16;
    localparam int MAP_W    = 32;
    localparam int CMD_W    = 2;
    localparam int WAYF_W   = 2;
    localparam int LEN_W    = 4;
    localparam int BUDGET_W = 16;
    localparam int CPI_W    = 4;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [31:0]      HASH_MULT    = 32'h9e37_79b1;
    localparam int               HASH_SHIFT_A = 11;
    localparam int               HASH_SHIFT_B = 16;
    localparam logic [PC_W-1:0]  CODE_FLOOR   = 16'h0080;
    localparam logic [CPI_W-1:0] COST_RESET   = 4'd8;

    // Register index as decoded from paddr[2]
    localparam logic REG_CPI = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_NOTIFY = 2'd2,
        CMD_FLUSH  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESOLVE
    } state_t;

    typedef struct packed {
        logic              hit;
        logic              stale;
        logic [WAYF_W-1:0] way;
        logic              evicted;
        logic [LEN_W-1:0]  cached_length;
        logic              run_block;
    } rsp_t;

    typedef struct packed {
        logic row_we;
        logic page_we;
        rsp_t rsp;
    } upd_t;

endpackage

`default_nettype wire

FILE: src/tbc_req_if.sv
// Request channel of the tag cache: valid/ready handshake plus command payload.
// Depends on tbc_pkg for field widths.
`default_nettype none

interface tbc_req_if;
    import tbc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [PC_W-1:0]     guest_pc;
    logic [MAP_W-1:0]    bank_mapping;
    logic [WAYF_W-1:0]   fill_way;
    logic [LEN_W-1:0]    block_length;
    logic [BUDGET_W-1:0] cycles_left;

    modport source (
        output valid, command, guest_pc, bank_mapping, fill_way, block_length, cycles_left,
        input  ready
    );

    modport sink (
        input  valid, command, guest_pc, bank_mapping, fill_way, block_length, cycles_left,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/tbc_rsp_if.sv
// Response channel of the tag cache: valid/ready handshake plus lookup result.
// Depends on tbc_pkg for field widths.
`default_nettype none

interface tbc_rsp_if;
    import tbc_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic              stale;
    logic [WAYF_W-1:0] way;
    logic              evicted;
    logic [LEN_W-1:0]  cached_length;
    logic              run_block;

    modport source (
        output valid, hit, stale, way, evicted, cached_length, run_block,
        input  ready
    );

    modport sink (
        input  valid, hit, stale, way, evicted, cached_length, run_block,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/tbc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module tbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data when no read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/tbc_resolve.sv
// Resolve stage: from one set row and the page generation, decide the outcome of
// a command and build the write-back row. Depends on tbc_pkg.
`default_nettype none

module tbc_resolve #(
    parameter int WAYS          = 4,
    parameter int GEN_BITS      = 16,
    parameter int MAX_BLOCK_LEN = 8,
    localparam int ENTRY_W      = tbc_pkg::PC_W + tbc_pkg::MAP_W + GEN_BITS + tbc_pkg::LEN_W,
    localparam int VP_W         = $clog2(WAYS),
    localparam int ROW_W        = VP_W + WAYS + WAYS * ENTRY_W
) (
    input  wire tbc_pkg::cmd_t                     cmd,
    input  wire logic [tbc_pkg::PC_W-1:0]          pc,
    input  wire logic [tbc_pkg::MAP_W-1:0]         map,
    input  wire logic [tbc_pkg::WAYF_W-1:0]        fway,
    input  wire logic [tbc_pkg::LEN_W-1:0]         blen,
    input  wire logic [tbc_pkg::BUDGET_W-1:0]      budget,
    input  wire logic [tbc_pkg::CPI_W-1:0]         cpi,
    input  wire logic [ROW_W-1:0]                  row_rd,
    input  wire logic [GEN_BITS-1:0]               pgen,
    output logic      [ROW_W-1:0]                  row_wr,
    output logic      [GEN_BITS-1:0]               pgen_wr,
    output tbc_pkg::upd_t                          upd
);
    import tbc_pkg::*;

    localparam int VALID_LSB = WAYS * ENTRY_W;
    localparam int VP_LSB    = VALID_LSB + WAYS;
    localparam int GEN_LSB   = LEN_W;
    localparam int MAP_LSB   = GEN_LSB + GEN_BITS;
    localparam int PC_LSB    = MAP_LSB + MAP_W;

    logic [WAYS-1:0]     valid;
    logic [WAYS-1:0]     match;
    logic [VP_W-1:0]     vp;
    logic [VP_W-1:0]     vp_inc;
    logic [VP_W-1:0]     match_way;
    logic [VP_W-1:0]     free_way;
    logic [VP_W-1:0]     fw;
    logic [ENTRY_W-1:0]  ent [WAYS];
    logic [ENTRY_W-1:0]  hit_ent;
    logic [GEN_BITS-1:0] hit_gen;
    logic [LEN_W-1:0]    hit_len;
    logic [LEN_W-1:0]    blen_sat;
    logic                found;
    logic                have_free;
    logic                fill_ok;

    function automatic logic fits(input logic [LEN_W-1:0] len,
                                  input logic [CPI_W-1:0] cost,
                                  input logic [BUDGET_W-1:0] limit);
        logic [LEN_W+CPI_W-1:0] prod;
        prod = (LEN_W+CPI_W)'(len) * (LEN_W+CPI_W)'(cost);
        return BUDGET_W'(prod) <= limit;
    endfunction

    // Unpack the row and match tags in every way
    always_comb
    begin
        valid = row_rd[VALID_LSB +: WAYS];
        vp    = row_rd[VP_LSB +: VP_W];
        for (int w = 0; w < WAYS; w++)
        begin
            ent[w]   = row_rd[w*ENTRY_W +: ENTRY_W];
            match[w] = valid[w]
                    && (ent[w][PC_LSB +: PC_W] == pc)
                    && (ent[w][MAP_LSB +: MAP_W] == map);
        end
        found     = |match;
        have_free = ~&valid;
        match_way = '0;
        free_way  = '0;
        // lowest way wins
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                match_way = VP_W'(w);
            end
            if (!valid[w])
            begin
                free_way = VP_W'(w);
            end
        end
        hit_ent  = ent[match_way];
        hit_gen  = hit_ent[GEN_LSB +: GEN_BITS];
        hit_len  = hit_ent[LEN_W-1:0];
        vp_inc   = (vp == VP_W'(WAYS - 1)) ? '0 : vp + 1'b1;
        fw       = VP_W'(fway);
        fill_ok  = 5'(fway) < 5'(WAYS);
        blen_sat = (blen > LEN_W'(MAX_BLOCK_LEN)) ? LEN_W'(MAX_BLOCK_LEN) : blen;
    end

    always_comb
    begin
        row_wr  = row_rd;
        pgen_wr = pgen + 1'b1;
        upd     = '0;
        unique case (cmd)
            CMD_LOOKUP:
            begin
                if (found)
                begin
                    upd.rsp.way = WAYF_W'(match_way);
                    if (hit_gen == pgen)
                    begin
                        upd.rsp.hit           = 1'b1;
                        upd.rsp.cached_length = hit_len;
                        upd.rsp.run_block     = fits(hit_len, cpi, budget);
                    end
                    else
                    begin
                        upd.rsp.stale = 1'b1;
                    end
                end
                else if (have_free)
                begin
                    upd.rsp.way = WAYF_W'(free_way);
                end
                else
                begin
                    // round-robin victim; advance the set pointer
                    upd.rsp.way                = WAYF_W'(vp);
                    upd.rsp.evicted            = 1'b1;
                    upd.row_we                 = 1'b1;
                    row_wr[VP_LSB +: VP_W]     = vp_inc;
                end
            end
            CMD_FILL:
            begin
                if (fill_ok)
                begin
                    upd.row_we  = 1'b1;
                    upd.rsp.way = fway;
                    if ((blen == '0) || (pc < CODE_FLOOR))
                    begin
                        row_wr[VALID_LSB + int'(fw)] = 1'b0;
                    end
                    else
                    begin
                        row_wr[VALID_LSB + int'(fw)]           = 1'b1;
                        row_wr[int'(fw)*ENTRY_W +: ENTRY_W]    = {pc, map, pgen, blen_sat};
                        upd.rsp.cached_length                  = blen_sat;
                        upd.rsp.run_block = fits(blen_sat, cpi, budget);
                    end
                end
            end
            CMD_NOTIFY:
            begin
                upd.page_we = (pc >= CODE_FLOOR);
            end
            CMD_FLUSH:
            begin
                // the controller runs the clearing sweep
                upd = '0;
            end
            default:
            begin
                upd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/translated_block_tag_cache.sv
// Top level of the translated block tag cache: controller, set/page memories,
// output register and APB register. Depends on tbc_pkg, tbc_req_if, tbc_rsp_if,
// tbc_ram, tbc_resolve and translated_block_tag_cache_assert.svh.
//
//  Channel  Dir  Handshake                      Transfer carries
//  req      in   valid/ready                    command, guest_pc, bank_mapping,
//                                               fill_way, block_length, cycles_left
//  rsp      out  valid/ready                    hit, stale, way, evicted,
//                                               cached_length, run_block
//  apb      in   psel/penable/pwrite, pready=1  cycles_per_instruction at 0x0
//
// Each command has an accept cycle and a resolve cycle: the accept cycle hashes the key and issues the
// set-row and page-generation reads, the resolve cycle compares the tags and
// writes the row or page back. The registered read of the memories and the
// write-back, which must land before the next read, set this.
// Reset and every flush start a clearing sweep that zeroes both memories; no
// command is taken meanwhile, register writes still are.
// A stalled rsp holds the resolve cycle until the output register frees up.
`default_nettype none

`include "translated_block_tag_cache_assert.svh"

module translated_block_tag_cache #(
    parameter int SET_BITS      = 10,
    parameter int WAYS          = 4,
    parameter int PAGE_SHIFT    = 8,
    parameter int GEN_BITS      = 16,
    parameter int MAX_BLOCK_LEN = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    tbc_req_if.sink                           req,
    tbc_rsp_if.source                         rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tbc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [tbc_pkg::APB_DW-1:0]   pwdata,
    output logic      [tbc_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);
    import tbc_pkg::*;

    localparam int NUM_SETS  = 1 << SET_BITS;
    localparam int PAGE_W    = PC_W - PAGE_SHIFT;
    localparam int NUM_PAGES = 1 << PAGE_W;
    localparam int CLR_DEPTH = (NUM_SETS > NUM_PAGES) ? NUM_SETS : NUM_PAGES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int ENTRY_W   = PC_W + MAP_W + GEN_BITS + LEN_W;
    localparam int VP_W      = $clog2(WAYS);
    localparam int ROW_W     = VP_W + WAYS + WAYS * ENTRY_W;

    state_t              state_reg, state_next;
    logic [CLR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CPI_W-1:0]    cpi_reg;
    logic                out_valid_reg, out_valid_next;
    rsp_t                rsp_reg;

    // Captured command
    cmd_t                cmd_reg;
    logic [PC_W-1:0]     pc_reg;
    logic [MAP_W-1:0]    map_reg;
    logic [WAYF_W-1:0]   fway_reg;
    logic [LEN_W-1:0]    blen_reg;
    logic [BUDGET_W-1:0] budget_reg;
    logic [SET_BITS-1:0] set_reg;

    logic                accept;
    logic                commit;
    logic                clearing;
    logic                clr_last;
    logic                out_free;
    logic [31:0]         hash_prod;
    logic [31:0]         hash_mix;
    logic [31:0]         hash_fold;
    logic [SET_BITS-1:0] set_in;

    logic [ROW_W-1:0]    row_rd, row_wr, row_wdata;
    logic [SET_BITS-1:0] row_waddr;
    logic                row_we;
    logic [GEN_BITS-1:0] pgen_rd, pgen_wr, pgen_wdata;
    logic [PAGE_W-1:0]   page_waddr;
    logic                page_we;
    upd_t                upd;

    // ------------------------------------------------------------------
    // Configuration register: written on the APB access phase
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpi_reg <= COST_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_CPI))
        begin
            cpi_reg <= pwdata[CPI_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CPI)
        begin
            prdata = APB_DW'(cpi_reg);
        end
    end

    // ------------------------------------------------------------------
    // Set hash on the incoming key; drives the row read address directly
    // ------------------------------------------------------------------
    always_comb
    begin
        hash_prod = 32'((PC_W+32)'(req.guest_pc) * (PC_W+32)'(HASH_MULT));
        hash_mix  = req.bank_mapping ^ (req.bank_mapping >> HASH_SHIFT_A) ^ hash_prod;
        hash_fold = hash_mix ^ (hash_mix >> HASH_SHIFT_B);
        set_in    = hash_fold[SET_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || rsp.ready;
    assign clr_last = (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next = (cmd_reg == CMD_FLUSH) ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        commit    = 1'b0;
        clearing  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:   clearing  = 1'b1;
            ST_IDLE:    req.ready = 1'b1;
            ST_RESOLVE: commit    = out_free;
            default:    clearing  = 1'b0;
        endcase
    end

    assign accept = req.valid && req.ready;

    // sweep counter wraps to zero at the end, ready for the next flush
    assign clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Capture the command at the transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(req.command);
            pc_reg     <= req.guest_pc;
            map_reg    <= req.bank_mapping;
            fway_reg   <= req.fill_way;
            blen_reg   <= req.block_length;
            budget_reg <= req.cycles_left;
            set_reg    <= set_in;
        end
    end

    // ------------------------------------------------------------------
    // Memories: one row per set (tags, valid bits, victim pointer) and
    // one write generation per page. Clearing writes zero rows.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (clearing)
        begin
            row_we     = 1'b1;
            row_waddr  = clr_cnt_reg[SET_BITS-1:0];
            row_wdata  = '0;
            page_we    = 1'b1;
            page_waddr = clr_cnt_reg[PAGE_W-1:0];
            pgen_wdata = '0;
        end
        else
        begin
            row_we     = commit && upd.row_we;
            row_waddr  = set_reg;
            row_wdata  = row_wr;
            page_we    = commit && upd.page_we;
            page_waddr = pc_reg[PC_W-1:PAGE_SHIFT];
            pgen_wdata = pgen_wr;
        end
    end

    tbc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (accept),
        .raddr (set_in),
        .rdata (row_rd)
    );

    tbc_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (NUM_PAGES)
    ) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (pgen_wdata),
        .re    (accept),
        .raddr (req.guest_pc[PC_W-1:PAGE_SHIFT]),
        .rdata (pgen_rd)
    );

    tbc_resolve #(
        .WAYS          (WAYS),
        .GEN_BITS      (GEN_BITS),
        .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
    ) u_resolve (
        .cmd     (cmd_reg),
        .pc      (pc_reg),
        .map     (map_reg),
        .fway    (fway_reg),
        .blen    (blen_reg),
        .budget  (budget_reg),
        .cpi     (cpi_reg),
        .row_rd  (row_rd),
        .pgen    (pgen_rd),
        .row_wr  (row_wr),
        .pgen_wr (pgen_wr),
        .upd     (upd)
    );

    // ------------------------------------------------------------------
    // Output register: load on commit, drop once the transfer completes
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            rsp_reg <= upd.rsp;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = rsp_reg.hit;
    assign rsp.stale         = rsp_reg.stale;
    assign rsp.way           = rsp_reg.way;
    assign rsp.evicted       = rsp_reg.evicted;
    assign rsp.cached_length = rsp_reg.cached_length;
    assign rsp.run_block     = rsp_reg.run_block;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TBC_ASSERT_SAME(a_commit_slot_free, commit, (!out_valid_reg || rsp.ready))
    `TBC_ASSERT_NEXT(a_accept_resolves, accept, (state_reg == ST_RESOLVE))
    `TBC_ASSERT_SAME(a_hit_excl_stale, rsp.valid, !(rsp.hit && rsp.stale))
    `TBC_ASSERT_SAME(a_run_has_len, (rsp.valid && rsp.run_block), (rsp.cached_length != '0))
    `TBC_ASSERT_SAME(a_evict_is_miss, (rsp.valid && rsp.evicted), !(rsp.hit || rsp.stale))

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for translated_block_tag_cache: a scoreboard class predicts every
// response from its own copy of the tag store, and plain tasks drive requests and APB writes.
// Depends on tbc_pkg, tbc_req_if and tbc_rsp_if.

module tb;
    import tbc_pkg::*;

    // Geometry of the block under test; passed to the instance as well.
    localparam int SETS_LOG2 = 10;
    localparam int N_WAYS    = 4;
    localparam int PG_SHIFT  = 8;
    localparam int GEN_W     = 16;
    localparam int LEN_MAX   = 8;

    localparam int NUM_SETS  = 1 << SETS_LOG2;
    localparam int NUM_LINES = NUM_SETS * N_WAYS;
    localparam int NUM_PAGES = 1 << (PC_W - PG_SHIFT);

    // APB byte addresses: the cost register, and one slot past it that decodes to nothing.
    localparam logic [APB_AW-1:0] ADDR_CPI   = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_SPARE = 3'd4;

    // Key pool: four groups of six keys sharing one set each, plus two keys below the floor.
    localparam int GROUPS    = 4;
    localparam int PER_GROUP = 6;
    localparam int NUM_KEYS  = GROUPS * PER_GROUP + 2;

    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 200;

    typedef struct packed {
        cmd_t                command;
        logic [PC_W-1:0]     guest_pc;
        logic [MAP_W-1:0]    bank_mapping;
        logic [WAYF_W-1:0]   fill_way;
        logic [LEN_W-1:0]    block_length;
        logic [BUDGET_W-1:0] cycles_left;
    } tag_req_t;

    // Tag store predictor plus the queue of responses still owed by the block.
    class tag_cache_scoreboard;
        bit                line_valid [NUM_LINES];
        bit [PC_W-1:0]     line_pc    [NUM_LINES];
        bit [MAP_W-1:0]    line_map   [NUM_LINES];
        bit [GEN_W-1:0]    line_gen   [NUM_LINES];
        bit [LEN_W-1:0]    line_len   [NUM_LINES];
        bit [GEN_W-1:0]    page_gen   [NUM_PAGES];
        bit [WAYF_W-1:0]   rr_ptr     [NUM_SETS];
        bit [CPI_W-1:0]    cost;
        rsp_t              awaited[$];
        int                errors;
        int                reports;

        function new();
            cost    = COST_RESET;
            errors  = 0;
            reports = 0;
        endfunction

        function int set_index(logic [PC_W-1:0] pc, logic [MAP_W-1:0] bank);
            logic [31:0] prod;
            logic [31:0] h;
            prod = {16'h0000, pc} * HASH_MULT;
            h = bank ^ (bank >> HASH_SHIFT_A) ^ prod;
            h = h ^ (h >> HASH_SHIFT_B);
            return int'(h[SETS_LOG2-1:0]);
        endfunction

        function bit fits(logic [LEN_W-1:0] len, logic [BUDGET_W-1:0] budget);
            return (int'(len) * int'(cost)) <= int'(budget);
        endfunction

        // Apply one accepted request to the model and queue the response it owes.
        function rsp_t note_request(tag_req_t r);
            rsp_t             p;
            int               base;
            int               e;
            int               w;
            int               hit_way;
            int               free_way;
            int               page;
            bit               found;
            bit               have_free;
            logic [LEN_W-1:0] len;
            p         = '0;
            found     = 1'b0;
            have_free = 1'b0;
            hit_way   = 0;
            free_way  = 0;
            base      = set_index(r.guest_pc, r.bank_mapping) * N_WAYS;
            page      = int'(r.guest_pc >> PG_SHIFT);
            case (r.command)
                CMD_LOOKUP:
                begin
                    for (w = 0; w < N_WAYS; w++)
                    begin
                        e = base + w;
                        if (line_valid[e] && line_pc[e] == r.guest_pc
                                && line_map[e] == r.bank_mapping)
                        begin
                            found   = 1'b1;
                            hit_way = w;
                            break;
                        end
                        if (!have_free && !line_valid[e])
                        begin
                            have_free = 1'b1;
                            free_way  = w;
                        end
                    end
                    if (found)
                    begin
                        e     = base + hit_way;
                        p.way = WAYF_W'(hit_way);
                        if (line_gen[e] == page_gen[page])
                        begin
                            p.hit           = 1'b1;
                            p.cached_length = line_len[e];
                            p.run_block     = fits(line_len[e], r.cycles_left);
                        end
                        else
                            p.stale = 1'b1;
                    end
                    else if (have_free)
                        p.way = WAYF_W'(free_way);
                    else
                    begin
                        w         = int'(rr_ptr[base / N_WAYS]) % N_WAYS;
                        p.way     = WAYF_W'(w);
                        p.evicted = 1'b1;
                        rr_ptr[base / N_WAYS] = WAYF_W'((w + 1) % N_WAYS);
                    end
                end
                CMD_FILL:
                begin
                    if (int'(r.fill_way) < N_WAYS)
                    begin
                        e     = base + int'(r.fill_way);
                        p.way = r.fill_way;
                        len   = r.block_length;
                        if (len == 0 || r.guest_pc < CODE_FLOOR)
                            line_valid[e] = 1'b0;
                        else
                        begin
                            if (int'(len) > LEN_MAX)
                                len = LEN_W'(LEN_MAX);
                            line_valid[e]   = 1'b1;
                            line_pc[e]      = r.guest_pc;
                            line_map[e]     = r.bank_mapping;
                            line_gen[e]     = page_gen[page];
                            line_len[e]     = len;
                            p.cached_length = len;
                            p.run_block     = fits(len, r.cycles_left);
                        end
                    end
                end
                CMD_NOTIFY:
                begin
                    if (r.guest_pc >= CODE_FLOOR)
                        page_gen[page] = page_gen[page] + 1'b1;
                end
                default:
                begin
                    foreach (line_valid[i])
                        line_valid[i] = 1'b0;
                    foreach (page_gen[i])
                        page_gen[i] = '0;
                    foreach (rr_ptr[i])
                        rr_ptr[i] = '0;
                end
            endcase
            awaited.push_back(p);
            return p;
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                if (reports < 200)
                begin
                    reports++;
                    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
                end
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                if (reports < 200)
                begin
                    reports++;
                    $display("%0t: response with nothing outstanding, expected none, got %0h",
                             $time, got);
                end
                return;
            end
            want = awaited.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("stale", want.stale, got.stale);
            compare_field("way", want.way, got.way);
            compare_field("evicted", want.evicted, got.evicted);
            compare_field("cached_length", want.cached_length, got.cached_length);
            compare_field("run_block", want.run_block, got.run_block);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    tbc_req_if req_ch ();
    tbc_rsp_if rsp_ch ();

    translated_block_tag_cache #(
        .SET_BITS      (SETS_LOG2),
        .WAYS          (N_WAYS),
        .PAGE_SHIFT    (PG_SHIFT),
        .GEN_BITS      (GEN_W),
        .MAX_BLOCK_LEN (LEN_MAX)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tag_cache_scoreboard sb = new();

    // Idling controls shared between the sender and the receiver.
    bit req_gaps      = 1'b0;
    bit rsp_stalls    = 1'b0;
    bit long_hold_req = 1'b0;
    int items_sent    = 0;

    logic [PC_W-1:0]  key_pc  [NUM_KEYS];
    logic [MAP_W-1:0] key_map [NUM_KEYS];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stall bursts, plus one long hold-off counted here so the block backs up.
    initial
    begin : receiver
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = 300;
            end
            else if (hold_left == 0 && rsp_stalls && $urandom_range(0, 7) == 0)
                hold_left = $urandom_range(1, 19);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Check every response transfer at the rising edge that completes it.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response({rsp_ch.hit, rsp_ch.stale, rsp_ch.way, rsp_ch.evicted,
                               rsp_ch.cached_length, rsp_ch.run_block});
    end

    function automatic tag_req_t make_req(cmd_t c, logic [PC_W-1:0] pc, logic [MAP_W-1:0] bank,
                                          logic [WAYF_W-1:0] way, logic [LEN_W-1:0] len,
                                          logic [BUDGET_W-1:0] budget);
        tag_req_t r;
        r.command      = c;
        r.guest_pc     = pc;
        r.bank_mapping = bank;
        r.fill_way     = way;
        r.block_length = len;
        r.cycles_left  = budget;
        return r;
    endfunction

    // Budgets cluster around the pass/fail threshold for the given length, with the extremes.
    function automatic logic [BUDGET_W-1:0] pick_budget(logic [LEN_W-1:0] len);
        int need;
        need = (int'(len) > LEN_MAX ? LEN_MAX : int'(len)) * int'(sb.cost);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return BUDGET_W'($urandom);
            default: return (need == 0) ? BUDGET_W'($urandom_range(0, 1))
                                        : BUDGET_W'(need + $urandom_range(0, 2) - 1);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer with valid
    // still high, so the caller either offers the next item or drops valid.
    task automatic send(tag_req_t r, output rsp_t pred);
        if (req_gaps && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= r.command;
        req_ch.guest_pc     <= r.guest_pc;
        req_ch.bank_mapping <= r.bank_mapping;
        req_ch.fill_way     <= r.fill_way;
        req_ch.block_length <= r.block_length;
        req_ch.cycles_left  <= r.cycles_left;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pred = sb.note_request(r);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold off until every owed response has come back.
    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (pready && addr == ADDR_CPI)
            sb.cost = data[CPI_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Drain, write the cost register, poke the unused slot, and read the cost back.
    task automatic set_cost(logic [CPI_W-1:0] value);
        wait_drain();
        apb_write(ADDR_CPI, {28'($urandom_range(0, 32'h0fff_ffff)), value});
        apb_write(ADDR_SPARE, $urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_CPI;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.compare_field("cycles_per_instruction", sb.cost, prdata[CPI_W-1:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Build keys that collide in one set per group so ways fill and round-robin kicks in.
    task automatic build_key_pool();
        int               g;
        int               k;
        int               target;
        logic [7:0]       page;
        logic [PC_W-1:0]  pc;
        logic [MAP_W-1:0] bank;
        for (g = 0; g < GROUPS; g++)
        begin
            case (g)
                0:       page = 8'h00;
                1:       page = 8'h12;
                2:       page = 8'h80;
                default: page = 8'hff;
            endcase
            for (k = 0; k < PER_GROUP; k++)
            begin
                pc   = {page, 8'($urandom_range(8'h80, 8'hff))};
                bank = $urandom;
                if (k == 0)
                    target = sb.set_index(pc, bank);
                else
                begin
                    while (sb.set_index(pc, bank) != target)
                    begin
                        pc   = {page, 8'($urandom_range(8'h80, 8'hff))};
                        bank = $urandom;
                    end
                end
                key_pc[g * PER_GROUP + k]  = pc;
                key_map[g * PER_GROUP + k] = bank;
            end
        end
        key_pc[NUM_KEYS - 2]  = CODE_FLOOR - 1'b1;
        key_map[NUM_KEYS - 2] = $urandom;
        key_pc[NUM_KEYS - 1]  = PC_W'($urandom_range(0, 16'h007f));
        key_map[NUM_KEYS - 1] = $urandom;
    endtask

    // Well-formed use: look up, refill the named way on a miss or stale hit, look up again.
    task automatic run_sequence(int k);
        rsp_t             pred;
        logic [LEN_W-1:0] len;
        send(make_req(CMD_LOOKUP, key_pc[k], key_map[k], WAYF_W'($urandom), LEN_W'($urandom),
                      pick_budget(LEN_W'($urandom_range(1, LEN_MAX)))), pred);
        if (!pred.hit)
        begin
            len = ($urandom_range(0, 9) == 0) ? '0 : LEN_W'($urandom_range(1, 15));
            send(make_req(CMD_FILL, key_pc[k], key_map[k], pred.way, len, pick_budget(len)),
                 pred);
            send(make_req(CMD_LOOKUP, key_pc[k], key_map[k], WAYF_W'($urandom),
                          LEN_W'($urandom), pick_budget(len)), pred);
        end
    endtask

    task automatic random_op();
        int               r;
        int               k;
        rsp_t             pred;
        logic [LEN_W-1:0] len;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, NUM_KEYS - 1);
        if (r < 45)
            run_sequence(k);
        else if (r < 60)
            send(make_req(CMD_LOOKUP, key_pc[k], key_map[k], WAYF_W'($urandom), LEN_W'($urandom),
                          pick_budget(LEN_W'($urandom_range(1, LEN_MAX)))), pred);
        else if (r < 72)
            // bump the page of a pooled key; page zero sometimes lands below the floor
            send(make_req(CMD_NOTIFY, {key_pc[k][PC_W-1:PG_SHIFT], 8'($urandom)}, $urandom,
                          WAYF_W'($urandom), LEN_W'($urandom), BUDGET_W'($urandom)), pred);
        else if (r < 82)
        begin
            len = LEN_W'($urandom_range(0, 15));
            send(make_req(CMD_FILL, key_pc[k], key_map[k], WAYF_W'($urandom), len,
                          pick_budget(len)), pred);
        end
        else if (r < 83)
            send(make_req(CMD_FLUSH, PC_W'($urandom), $urandom, WAYF_W'($urandom),
                          LEN_W'($urandom), BUDGET_W'($urandom)), pred);
        else
            send(make_req(cmd_t'($urandom_range(0, 2)), PC_W'($urandom), $urandom,
                          WAYF_W'($urandom), LEN_W'($urandom), BUDGET_W'($urandom)), pred);
    endtask

    // Edge cases at reset cost (8): hit budget threshold, length clamp, invalidating
    // fills, round-robin eviction, stale hit after a write, notify floor, flush.
    task automatic directed_part();
        rsp_t pred;
        send(make_req(CMD_LOOKUP, key_pc[0], key_map[0], 2'd0, 4'd0, 16'd0), pred);
        send(make_req(CMD_FILL, key_pc[0], key_map[0], 2'd0, 4'd8, 16'd64), pred);
        send(make_req(CMD_LOOKUP, key_pc[0], key_map[0], 2'd3, 4'd15, 16'd63), pred);
        send(make_req(CMD_LOOKUP, key_pc[0], key_map[0], 2'd0, 4'd0, 16'hffff), pred);
        send(make_req(CMD_FILL, key_pc[1], key_map[1], 2'd1, 4'd15, 16'd0), pred);
        send(make_req(CMD_FILL, key_pc[2], key_map[2], 2'd2, 4'd0, 16'hffff), pred);
        send(make_req(CMD_FILL, key_pc[2], key_map[2], 2'd2, 4'd1, 16'd8), pred);
        send(make_req(CMD_FILL, key_pc[3], key_map[3], 2'd3, 4'd4, 16'hffff), pred);
        send(make_req(CMD_FILL, CODE_FLOOR - 1'b1, key_map[0], 2'd0, 4'd5, 16'hffff), pred);
        // all four ways of the group set are valid now: two round-robin victims
        send(make_req(CMD_LOOKUP, key_pc[4], key_map[4], 2'd0, 4'd0, 16'hffff), pred);
        send(make_req(CMD_LOOKUP, key_pc[5], key_map[5], 2'd0, 4'd0, 16'hffff), pred);
        send(make_req(CMD_NOTIFY, CODE_FLOOR - 1'b1, 32'h0, 2'd0, 4'd0, 16'h0), pred);
        send(make_req(CMD_LOOKUP, key_pc[0], key_map[0], 2'd0, 4'd0, 16'hffff), pred);
        send(make_req(CMD_NOTIFY, CODE_FLOOR, 32'hffff_ffff, 2'd3, 4'd15, 16'hffff), pred);
        send(make_req(CMD_LOOKUP, key_pc[0], key_map[0], 2'd0, 4'd0, 16'hffff), pred);
        send(make_req(CMD_FILL, key_pc[0], key_map[0], pred.way, 4'd2, 16'd16), pred);
        send(make_req(CMD_LOOKUP, key_pc[0], key_map[0], 2'd0, 4'd0, 16'd15), pred);
        send(make_req(CMD_NOTIFY, 16'hffff, 32'h0, 2'd0, 4'd0, 16'h0), pred);
        send(make_req(CMD_LOOKUP, 16'hffff, 32'hffff_ffff, 2'd3, 4'd15, 16'hffff), pred);
        send(make_req(CMD_LOOKUP, 16'h0000, 32'h0, 2'd0, 4'd0, 16'h0), pred);
        send(make_req(CMD_FILL, 16'hffff, 32'hffff_ffff, 2'd3, 4'd9, 16'hffff), pred);
        send(make_req(CMD_LOOKUP, 16'hffff, 32'hffff_ffff, 2'd0, 4'd0, 16'd64), pred);
        send(make_req(CMD_FLUSH, 16'h0, 32'h0, 2'd0, 4'd0, 16'h0), pred);
        send(make_req(CMD_LOOKUP, key_pc[0], key_map[0], 2'd0, 4'd0, 16'hffff), pred);
        send(make_req(CMD_LOOKUP, 16'hffff, 32'hffff_ffff, 2'd0, 4'd0, 16'hffff), pred);
    endtask

    initial
    begin : stimulus
        int ph;
        int ops;
        int phase_end;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_LOOKUP;
        req_ch.guest_pc     = '0;
        req_ch.bank_mapping = '0;
        req_ch.fill_way     = '0;
        req_ch.block_length = '0;
        req_ch.cycles_left  = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        build_key_pool();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part runs at the reset cost with no idling; the block clears first.
        directed_part();

        ops = 0;
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       set_cost(4'd15);
                1:       set_cost(4'd1);
                2:       set_cost(4'd0);
                3:       set_cost(CPI_W'($urandom_range(2, 14)));
                default: set_cost(COST_RESET);
            endcase
            if (ph == 1)
            begin
                // long receiver hold-off while requests keep coming back to back
                req_gaps      = 1'b0;
                long_hold_req = 1'b1;
                repeat (20) run_sequence($urandom_range(0, NUM_KEYS - 1));
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if (ops % 40 == 0)
                begin
                    req_gaps   = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                    rsp_stalls = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                end
                ops++;
                random_op();
            end
        end

        // Let the pipeline empty, then keep the clock running for stray responses before reporting.
        req_gaps   = 1'b0;
        rsp_stalls = 1'b0;
        wait_drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog, several times the slowest legal run including the clearing sweeps.
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
